// ----- design/acs_pkg.sv -----
// Shared types, constants and helper functions for the accumulator CPU step core.
// No dependencies; every other design file imports this package.
package acs_pkg;

    localparam int MEM_WORDS_DEFAULT = 8192;

    // Operation codes of the input transaction
    localparam logic [1:0] OPN_STEP  = 2'd0;
    localparam logic [1:0] OPN_WRITE = 2'd1;
    localparam logic [1:0] OPN_READ  = 2'd2;

    // Classified kinds handed to the back end
    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // Instruction opcodes
    localparam logic [3:0] OP_OR    = 4'h0;
    localparam logic [3:0] OP_AND   = 4'h1;
    localparam logic [3:0] OP_XOR   = 4'h2;
    localparam logic [3:0] OP_ADD   = 4'h3;
    localparam logic [3:0] OP_SHL   = 4'h4;
    localparam logic [3:0] OP_SHR   = 4'h5;
    localparam logic [3:0] OP_LOADI = 4'h6;
    localparam logic [3:0] OP_STORI = 4'h7;
    localparam logic [3:0] OP_LOAD  = 4'h8;
    localparam logic [3:0] OP_STORE = 4'h9;
    localparam logic [3:0] OP_LIT   = 4'hA;
    localparam logic [3:0] OP_NOP   = 4'hB;
    localparam logic [3:0] OP_JMP   = 4'hC;
    localparam logic [3:0] OP_JZ    = 4'hD;
    localparam logic [3:0] OP_SET   = 4'hE;
    localparam logic [3:0] OP_GET   = 4'hF;

    // Flag bit positions
    localparam int FLAG_CARRY = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_NEG   = 2;
    localparam int FLAG_RESET = 3;
    localparam int FLAG_HALT  = 4;
    localparam logic [15:0] FLAG_INIT = 16'h0002;

    // I/O decode
    localparam int IO_BIT = 14;
    localparam int TX_BIT = 13;
    localparam int RX_BIT = 10;
    localparam logic [2:0] IO_SWITCH = 3'd0;
    localparam logic [2:0] IO_SERIAL = 3'd1;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        addr_ok;
        logic [15:0] mem_addr;
        logic [15:0] write_data;
        logic [15:0] switches;
        logic [7:0]  rx_byte;
        logic        rx_ready;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

    typedef struct packed {
        logic [15:0] prog_counter;
        logic [15:0] accum;
        logic [15:0] flag_word;
        logic [15:0] led_levels;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_taken;
        logic        halted;
        logic [15:0] read_data;
    } result_t;

    // Reduce a word address into the memory range; m is at least 4096.
    function automatic logic [15:0] wrap_word(input logic [15:0] a, input logic [16:0] m);
        logic [19:0] x;
        logic [19:0] d;
        x = {4'd0, a};
        for (int s = 3; s >= 0; s--)
        begin
            d = {3'd0, m} << s;
            if (x >= d)
            begin
                x = x - d;
            end
        end
        return x[15:0];
    endfunction

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [2:0] nib [4];
        for (int i = 0; i < 4; i++)
        begin
            nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
        end
        return 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
    endfunction

endpackage

// ----- design/acs_front.sv -----
// Front end: accepts input transactions, classifies them, pre-wraps the address.
// Depends on acs_pkg.
module acs_front #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEFAULT
) (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [12:0]       address,
    input  logic [15:0]       write_data,
    input  logic [15:0]       switches,
    input  logic [7:0]        rx_byte,
    input  logic              rx_ready,
    input  logic              q_full,
    output acs_pkg::push_t    push
);
    import acs_pkg::*;

    localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

    logic [15:0] addr_ext;

    assign addr_ext = {3'd0, address};
    assign in_stall = q_full;

    always_comb
    begin
        push.push            = in_valid && !q_full;
        push.item.addr_ok    = ({1'b0, addr_ext} < MEM_LIMIT);
        push.item.mem_addr   = wrap_word(addr_ext, MEM_LIMIT);
        push.item.write_data = write_data;
        push.item.switches   = switches;
        push.item.rx_byte    = rx_byte;
        push.item.rx_ready   = rx_ready;
        case (operation)
            OPN_STEP:  push.item.kind = KIND_STEP;
            OPN_WRITE: push.item.kind = KIND_WRITE;
            OPN_READ:  push.item.kind = KIND_READ;
            default:   push.item.kind = KIND_NOP;
        endcase
    end

endmodule

// ----- design/acs_queue.sv -----
// Short FIFO of classified transactions between front and back end.
// Depends on acs_pkg.
module acs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  acs_pkg::push_t    push,
    output logic              full,
    output logic              head_valid,
    output acs_pkg::item_t    head,
    input  logic              pop
);
    import acs_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    item_t          entry_reg [Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ----- design/acs_exec.sv -----
// Back end: CPU state, word memory, instruction sequencer and result register.
// Depends on acs_pkg.
module acs_exec #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  acs_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output acs_pkg::result_t  result
);
    import acs_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_OPND   = 3'd3;
    localparam logic [2:0] ST_EXEC   = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [15:0] mem_array [MEM_WORDS];
    logic [15:0] mem_rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [15:0]   mem_wdata;

    logic [2:0]  state_reg, state_next;
    item_t       cur_reg, cur_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] flag_reg, flag_next;
    logic [15:0] led_reg, led_next;
    logic [7:0]  rx_latch_reg, rx_latch_next;
    logic [3:0]  code_reg, code_next;
    logic [15:0] lop_reg, lop_next;
    result_t     side_reg, side_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] flag_ref;
    logic [15:0] pc_wrap;
    logic [15:0] lop_wrap;
    logic [15:0] io_rd;
    logic [16:0] sum;
    logic [4:0]  shamt;

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign pc_wrap   = wrap_word(pc_reg, MEM_LIMIT);
    assign lop_wrap  = wrap_word(lop_reg, MEM_LIMIT);
    assign sum       = {1'b0, acc_reg} + {1'b0, lop_reg};
    assign shamt     = popcount16(lop_reg);

    always_comb
    begin
        flag_ref            = flag_reg;
        flag_ref[FLAG_ZERO] = (acc_reg == 16'd0);
        flag_ref[FLAG_NEG]  = acc_reg[15];
    end

    always_comb
    begin
        case (lop_reg[2:0])
            IO_SWITCH: io_rd = cur_reg.switches;
            IO_SERIAL: io_rd = {7'd0, ~cur_reg.rx_ready, rx_latch_reg};
            default:   io_rd = 16'd0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        flag_next      = flag_reg;
        led_next       = led_reg;
        rx_latch_next  = rx_latch_reg;
        code_next      = code_reg;
        lop_next       = lop_reg;
        side_next      = side_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        mem_addr       = '0;
        mem_we         = 1'b0;
        mem_wdata      = acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_item;
                    side_next = '0;
                    mem_addr  = q_item.mem_addr[AW-1:0];
                    case (q_item.kind)
                        KIND_WRITE:
                        begin
                            mem_we     = q_item.addr_ok;
                            mem_wdata  = q_item.write_data;
                            state_next = ST_DONE;
                        end
                        KIND_READ:
                        begin
                            state_next = ST_RDWAIT;
                        end
                        KIND_STEP:
                        begin
                            if (flag_ref[FLAG_HALT])
                            begin
                                flag_next        = flag_ref;
                                side_next.halted = 1'b1;
                                state_next       = ST_DONE;
                            end
                            else if (flag_ref[FLAG_RESET])
                            begin
                                pc_next    = 16'd0;
                                acc_next   = 16'd0;
                                flag_next  = 16'd0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                flag_next  = flag_ref;
                                mem_addr   = pc_wrap[AW-1:0];
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                side_next.read_data = mem_rdata_reg;
                state_next          = ST_DONE;
            end
            ST_FETCH:
            begin
                code_next = mem_rdata_reg[15:12];
                if (!mem_rdata_reg[15])
                begin
                    // indirect: operand names the word holding the value
                    mem_addr   = AW'(mem_rdata_reg[11:0]);
                    state_next = ST_OPND;
                end
                else
                begin
                    lop_next   = {4'd0, mem_rdata_reg[11:0]};
                    state_next = ST_EXEC;
                end
            end
            ST_OPND:
            begin
                lop_next   = mem_rdata_reg;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pc_next    = pc_reg + 16'd1;
                state_next = ST_DONE;
                case (code_reg)
                    OP_OR:  acc_next = acc_reg | lop_reg;
                    OP_AND: acc_next = acc_reg & lop_reg;
                    OP_XOR: acc_next = acc_reg ^ lop_reg;
                    OP_ADD:
                    begin
                        acc_next             = sum[15:0];
                        flag_next[FLAG_CARRY] = sum[16];
                    end
                    OP_SHL: acc_next = (shamt[4]) ? 16'd0 : (acc_reg << shamt[3:0]);
                    OP_SHR: acc_next = (shamt[4]) ? 16'd0 : (acc_reg >> shamt[3:0]);
                    OP_LOADI, OP_LOAD:
                    begin
                        if (lop_reg[IO_BIT])
                        begin
                            acc_next = io_rd;
                        end
                        else
                        begin
                            mem_addr   = lop_wrap[AW-1:0];
                            state_next = ST_LOAD;
                        end
                    end
                    OP_STORI, OP_STORE:
                    begin
                        if (lop_reg[IO_BIT])
                        begin
                            case (lop_reg[2:0])
                                IO_SWITCH: led_next = acc_reg;
                                IO_SERIAL:
                                begin
                                    if (acc_reg[TX_BIT])
                                    begin
                                        side_next.tx_valid = 1'b1;
                                        side_next.tx_byte  = acc_reg[7:0];
                                    end
                                    if (acc_reg[RX_BIT])
                                    begin
                                        rx_latch_next      = cur_reg.rx_byte;
                                        side_next.rx_taken = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        else if ({1'b0, lop_reg} < MEM_LIMIT)
                        begin
                            mem_we   = 1'b1;
                            mem_addr = lop_reg[AW-1:0];
                        end
                    end
                    OP_LIT: acc_next = lop_reg;
                    OP_NOP: ;
                    OP_JMP: pc_next = lop_reg;
                    OP_JZ:
                    begin
                        if (acc_reg == 16'd0)
                        begin
                            pc_next = lop_reg;
                        end
                    end
                    OP_SET:
                    begin
                        if (lop_reg[0])
                        begin
                            flag_next = acc_reg;
                        end
                        else
                        begin
                            pc_next = acc_reg;
                        end
                    end
                    default:
                    begin
                        acc_next = (lop_reg[0]) ? flag_reg : pc_reg;
                    end
                endcase
            end
            ST_LOAD:
            begin
                acc_next   = mem_rdata_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next              = side_reg;
                    out_next.prog_counter = pc_reg;
                    out_next.accum        = acc_reg;
                    out_next.flag_word    = flag_reg;
                    out_next.led_levels   = led_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 16'd0;
            acc_reg       <= 16'd0;
            flag_reg      <= FLAG_INIT;
            led_reg       <= 16'd0;
            rx_latch_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            flag_reg      <= flag_next;
            led_reg       <= led_next;
            rx_latch_reg  <= rx_latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        code_reg <= code_next;
        lop_reg  <= lop_next;
        side_reg <= side_next;
        out_reg  <= out_next;
    end

    // Single-port word memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem_array[mem_addr];
    end

endmodule

// ----- design/accumulator_cpu_step_core.sv -----
// Top level of the accumulator CPU step core: front end, queue, back end.
// Depends on acs_pkg, acs_front, acs_queue, acs_exec.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  input   | in_valid/in_stall  | operation address write_data switches rx_byte
//          |                    | rx_ready
//  output  | out_valid/out_stall| prog_counter accum flag_word led_levels tx_valid
//          |                    | tx_byte rx_taken halted read_data
//
// Back end states per transaction: memory write IDLE, DONE; memory read IDLE,
// RDWAIT, DONE; halted or reset step IDLE, DONE; direct instruction IDLE, FETCH,
// EXEC, DONE; indirect adds OPND after FETCH, a load from memory LOAD after EXEC.
// Fetch, operand and load reads share the single-port, registered-read memory.
// The two-entry queue lets the front accept transactions while the back works.
// Reset (rst_n low, asynchronous) clears pc, accumulator, LEDs, receive latch,
// sets the zero flag and empties the queue; memory contents stay undefined.
// A stalled result holds in the output register; the back end waits there.
module accumulator_cpu_step_core #(
    parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [12:0] address,
    input  logic [15:0] write_data,
    input  logic [15:0] switches,
    input  logic [7:0]  rx_byte,
    input  logic        rx_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] prog_counter,
    output logic [15:0] accum,
    output logic [15:0] flag_word,
    output logic [15:0] led_levels,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        rx_taken,
    output logic        halted,
    output logic [15:0] read_data
);
    import acs_pkg::*;

    push_t   push;
    logic    q_full;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    // front end: classify and wrap the address
    acs_front #(
        .MEM_WORDS (MEM_WORDS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .address    (address),
        .write_data (write_data),
        .switches   (switches),
        .rx_byte    (rx_byte),
        .rx_ready   (rx_ready),
        .q_full     (q_full),
        .push       (push)
    );

    // decoupling queue
    acs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_item),
        .pop        (q_pop)
    );

    // back end: sequencer, CPU state and memory
    acs_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (res)
    );

    assign prog_counter = res.prog_counter;
    assign accum        = res.accum;
    assign flag_word    = res.flag_word;
    assign led_levels   = res.led_levels;
    assign tx_valid     = res.tx_valid;
    assign tx_byte      = res.tx_byte;
    assign rx_taken     = res.rx_taken;
    assign halted       = res.halted;
    assign read_data    = res.read_data;

    // a character byte shows only with a transmit
    a_tx_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
        else $error("tx_byte set without tx_valid");

    // a halted step does no I/O and comes with the halt flag set
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted) |-> (flag_word[FLAG_HALT] && !tx_valid && !rx_taken
                                   && read_data == 16'd0))
        else $error("halted result carries side effects");

    // memory read data never coincides with serial activity
    a_read_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_data != 16'd0) |-> (!tx_valid && !rx_taken && !halted))
        else $error("read result mixed with step result");

endmodule
